/* rtl/avt_pkg.sv */
// ----------------------------------------------------------------------------
// avt_pkg
// Shared constants and types for the affine vertex transform engine.
// ----------------------------------------------------------------------------
package avt_pkg;

  localparam int FracBits   = 16;
  localparam int Rows       = 3;
  localparam int Cols       = 4;
  localparam int MatSize    = Rows * Cols;
  localparam int StoreDepth = 2 * MatSize;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int WeightW    = 17;
  localparam int WeightOne  = 65536;
  localparam int ProdW      = 64;
  localparam int SumW       = ProdW + 3;
  localparam int CmdqDepth  = 4;
  localparam int CmdqPtrW   = $clog2(CmdqDepth);
  localparam int ResqDepth  = 8;
  localparam int ResqPtrW   = $clog2(ResqDepth);
  localparam int StagesN    = 4;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdVertex = 1'b1;

  localparam logic [1:0] ModeAffine   = 2'd0;
  localparam logic [1:0] ModeRotScale = 2'd1;
  localparam logic [1:0] ModeSkin     = 2'd2;

  typedef struct packed {
    logic                      is_load;
    logic [AddrW-1:0]          addr;
    logic [31:0]               coef;
    logic signed [31:0]        x;
    logic signed [31:0]        y;
    logic signed [31:0]        z;
    logic [WeightW-1:0]        w;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } result_t;

endpackage

/* rtl/avt_front.sv */
// ----------------------------------------------------------------------------
// avt_front
// Accepts input beats, drops out-of-range loads, clamps weights, queues items.
// ----------------------------------------------------------------------------
module avt_front import avt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               cmd_i,
  input  logic               matrix_sel_i,
  input  logic [3:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] vert_x_i,
  input  logic signed [31:0] vert_y_i,
  input  logic signed [31:0] vert_z_i,
  input  logic [16:0]        blend_weight_i,
  input  logic               last_in_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output item_t              item_o
);

  item_t                mem_q [CmdqDepth];
  logic [CmdqPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CmdqPtrW:0]    cnt_q, cnt_d;
  item_t                item;
  logic                 enq, deq;

  always_comb begin
    item.is_load = (cmd_i == CmdLoad);
    item.addr    = AddrW'(coef_index_i) + (matrix_sel_i ? AddrW'(MatSize) : AddrW'(0));
    item.coef    = coef_value_i;
    item.x       = vert_x_i;
    item.y       = vert_y_i;
    item.z       = vert_z_i;
    item.w       = (blend_weight_i > WeightW'(WeightOne)) ? WeightW'(WeightOne)
                                                          : blend_weight_i;
    item.last    = last_in_i;
  end

  assign full = (cnt_q == (CmdqPtrW+1)'(CmdqDepth));
  // drop loads beyond the matrix
  assign enq  = push && !full &&
                !(item.is_load && (coef_index_i >= 4'(MatSize)));
  assign deq  = item_valid_o && item_ready_i;

  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = enq ? wr_q + 1'b1 : wr_q;
    rd_d  = deq ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (enq ? 1'b1 : 1'b0) - (deq ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_q] <= item;
    end
  end

endmodule

/* rtl/avt_back.sv */
// ----------------------------------------------------------------------------
// avt_back
// Coefficient store and four-stage transform pipeline with skin blend.
// ----------------------------------------------------------------------------
module avt_back import avt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          mode_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  item_t               item_i,
  input  logic [ResqPtrW:0]   res_count_i,
  output logic                res_push_o,
  output result_t             res_o
);

  localparam logic signed [SumW-1:0] SatMax  = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatMin  = SumW'(-64'sd2147483648);
  localparam logic signed [SumW-1:0] RndHalf = SumW'(1) <<< (FracBits - 1);

  logic [31:0]                coef_q [StoreDepth];

  logic [StagesN-1:0]         vld_q;
  logic [ResqPtrW+1:0]        occupancy;
  logic                       take, vtx, skin, trans_en;

  logic signed [ProdW-1:0]    p_d [2][Rows][3];
  logic signed [ProdW-1:0]    p_q [2][Rows][3];
  logic signed [31:0]         t_d [2][Rows];
  logic signed [31:0]         t_q [2][Rows];
  logic [WeightW-1:0]         w1_q, w2_q, w3_q;
  logic [StagesN-1:0]         last_q;
  logic                       sk1_q, sk2_q;

  logic signed [SumW-1:0]     s01_q [2][Rows];
  logic signed [SumW-1:0]     s2t_q [2][Rows];

  logic signed [31:0]         a_d [Rows];
  logic signed [31:0]         b_d [Rows];
  logic signed [31:0]         a3_q [Rows];
  logic signed [31:0]         b3_q [Rows];

  logic signed [50:0]         m_d [Rows];
  logic signed [50:0]         m4_q [Rows];
  logic signed [31:0]         b4_q [Rows];
  logic signed [31:0]         r_d [Rows];

  assign skin      = (mode_i == ModeSkin);
  assign trans_en  = (mode_i != ModeRotScale);
  assign occupancy = (ResqPtrW+2)'(res_count_i) + (ResqPtrW+2)'($countones(vld_q));
  assign item_ready_o = item_i.is_load || (occupancy < (ResqPtrW+2)'(ResqDepth));
  assign take      = item_valid_i && item_ready_o;
  assign vtx       = take && !item_i.is_load;

  always_ff @(posedge clk_i) begin
    if (take && item_i.is_load) begin
      coef_q[item_i.addr] <= item_i.coef;
    end
  end

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      for (int r = 0; r < Rows; r++) begin
        p_d[m][r][0] = $signed(coef_q[m*MatSize + r*Cols + 0]) * item_i.x;
        p_d[m][r][1] = $signed(coef_q[m*MatSize + r*Cols + 1]) * item_i.y;
        p_d[m][r][2] = $signed(coef_q[m*MatSize + r*Cols + 2]) * item_i.z;
        t_d[m][r]    = trans_en ? $signed(coef_q[m*MatSize + r*Cols + 3]) : 32'sd0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      logic signed [SumW-1:0] tot_a, tot_b, sh_a, sh_b;
      tot_a = s01_q[0][r] + s2t_q[0][r] + RndHalf;
      tot_b = s01_q[1][r] + s2t_q[1][r] + RndHalf;
      sh_a  = tot_a >>> FracBits;
      sh_b  = tot_b >>> FracBits;
      priority if (sh_a > SatMax) a_d[r] = 32'sh7fffffff;
      else if (sh_a < SatMin)     a_d[r] = 32'sh80000000;
      else                        a_d[r] = sh_a[31:0];
      priority if (!sk2_q)        b_d[r] = a_d[r];
      else if (sh_b > SatMax)     b_d[r] = 32'sh7fffffff;
      else if (sh_b < SatMin)     b_d[r] = 32'sh80000000;
      else                        b_d[r] = sh_b[31:0];
    end
  end

  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      logic signed [32:0] diff;
      logic signed [50:0] rnd;
      diff   = {a3_q[r][31], a3_q[r]} - {b3_q[r][31], b3_q[r]};
      m_d[r] = diff * $signed({1'b0, w3_q});
      rnd    = (m4_q[r] + 51'sd32768) >>> 16;
      r_d[r] = b4_q[r] + rnd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[StagesN-2:0], vtx};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    t_q    <= t_d;
    w1_q   <= skin ? item_i.w : WeightW'(WeightOne);
    sk1_q  <= skin;
    last_q <= {last_q[StagesN-2:0], item_i.last};
    for (int m = 0; m < 2; m++) begin
      for (int r = 0; r < Rows; r++) begin
        s01_q[m][r] <= SumW'(p_q[m][r][0]) + SumW'(p_q[m][r][1]);
        s2t_q[m][r] <= SumW'(p_q[m][r][2]) + (SumW'(t_q[m][r]) <<< FracBits);
      end
    end
    w2_q  <= w1_q;
    sk2_q <= sk1_q;
    a3_q  <= a_d;
    b3_q  <= b_d;
    w3_q  <= w2_q;
    m4_q  <= m_d;
    b4_q  <= b3_q;
  end

  assign res_push_o = vld_q[StagesN-1];
  assign res_o.x    = r_d[0];
  assign res_o.y    = r_d[1];
  assign res_o.z    = r_d[2];
  assign res_o.last = last_q[StagesN-1];

endmodule

/* rtl/avt_resq.sv */
// ----------------------------------------------------------------------------
// avt_resq
// Result queue that holds finished vertices until popped.
// ----------------------------------------------------------------------------
module avt_resq import avt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  result_t           data_i,
  output logic              empty,
  input  logic              pop,
  output result_t           data_o,
  output logic [ResqPtrW:0] count_o
);

  result_t              mem_q [ResqDepth];
  logic [ResqPtrW-1:0]  wr_q, rd_q;
  logic [ResqPtrW:0]    cnt_q;
  logic                 deq;

  assign empty   = (cnt_q == '0);
  assign deq     = pop && !empty;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (deq)    rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (push_i ? 1'b1 : 1'b0) - (deq ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/affine_vertex_transform_skin.sv */
// ----------------------------------------------------------------------------
// affine_vertex_transform_skin
// Q16.16 3x4 affine vertex transform with two-matrix skin blend.
// ----------------------------------------------------------------------------
// channel  | handshake                     | payload
// input    | push / full                   | cmd, matrix_sel, coef_index, coef_value,
//          |                               | vert_x/y/z, blend_weight, last_in
// result   | empty / pop                   | out_x/y/z, last_out
// config   | cfg_valid / cfg_ready         | cfg_mode
//
// One beat per cycle on input while not full and on result while not empty;
// a vertex goes through the input queue, four pipeline stages and the result queue.
// The rate is set by the 18 parallel multipliers of the first stage.
// Reset clears queues and mode; the coefficient store is undefined until loaded.
// The input queue stalls only when the result queue plus pipeline is full.
module affine_vertex_transform_skin import avt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               cmd_i,
  input  logic               matrix_sel_i,
  input  logic [3:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] vert_x_i,
  input  logic signed [31:0] vert_y_i,
  input  logic signed [31:0] vert_z_i,
  input  logic [16:0]        blend_weight_i,
  input  logic               last_in_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               last_out_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_mode_i
);

  logic [1:0]          mode_q;
  logic                item_valid, item_ready, res_push;
  item_t               item;
  result_t             res_in, res_out;
  logic [ResqPtrW:0]   res_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeAffine;
    end else if (cfg_valid && cfg_ready) begin
      mode_q <= cfg_mode_i;
    end
  end

  avt_front u_front (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .matrix_sel_i, .coef_index_i,
    .coef_value_i, .vert_x_i, .vert_y_i, .vert_z_i, .blend_weight_i, .last_in_i,
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  avt_back u_back (
    .clk_i, .rst_ni,
    .mode_i       (mode_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_count_i  (res_count),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  avt_resq u_resq (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .data_i  (res_in),
    .empty,
    .pop,
    .data_o  (res_out),
    .count_o (res_count)
  );

  assign out_x_o    = res_out.x;
  assign out_y_o    = res_out.y;
  assign out_z_o    = res_out.z;
  assign last_out_o = res_out.last;

endmodule

/* rtl/avt_checker.sv */
// ----------------------------------------------------------------------------
// avt_checker
// Port-level checks for the vertex transform engine.
// ----------------------------------------------------------------------------
module avt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        cfg_ready,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [31:0] out_z_o,
  input logic        last_out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_x_o) && $stable(out_y_o) &&
                          $stable(out_z_o) && $stable(last_out_o)))
    else $error("result changed while stalled");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("config channel not ready");

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_rst_full: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("input queue full after reset");

endmodule

bind affine_vertex_transform_skin avt_checker u_avt_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .cfg_ready,
  .out_x_o, .out_y_o, .out_z_o, .last_out_o
);

/* tb/sv/tb_affine_vertex_transform_skin.sv */
// ----------------------------------------------------------------------------
// tb_affine_vertex_transform_skin
// Self-checking testbench for the Q16.16 affine vertex transform engine.
// Coefficient loads and vertices are pushed with random gaps and results are
// popped with random stalls. A behavioural transform predicts every vertex
// result, and each popped beat is compared field by field with the oldest
// prediction. All modes get a random part, all but the spare a directed one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_affine_vertex_transform_skin;
  import avt_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;

  typedef struct {
    logic        cmd;
    logic        sel;
    logic [3:0]  idx;
    logic [31:0] coef;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [16:0] w;
    logic        last;
  } vtx_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               cmd_i = CmdLoad;
  logic               matrix_sel_i = 1'b0;
  logic [3:0]         coef_index_i = '0;
  logic signed [31:0] coef_value_i = '0;
  logic signed [31:0] vert_x_i = '0;
  logic signed [31:0] vert_y_i = '0;
  logic signed [31:0] vert_z_i = '0;
  logic [16:0]        blend_weight_i = '0;
  logic               last_in_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic               last_out_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_mode_i = ModeAffine;

  logic [31:0] coef_mirror [StoreDepth];
  logic [1:0]  mode_mirror = ModeAffine;
  result_t     expected_q [$];
  int          mismatches = 0;
  bit          push_gaps_on = 1'b1;
  bit          pop_stalls_on = 1'b1;
  int          pop_stall = 0;

  affine_vertex_transform_skin i_dut (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .matrix_sel_i, .coef_index_i,
    .coef_value_i, .vert_x_i, .vert_y_i, .vert_z_i, .blend_weight_i, .last_in_i,
    .empty, .pop, .out_x_o, .out_y_o, .out_z_o, .last_out_o,
    .cfg_valid, .cfg_ready, .cfg_mode_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint row_value(int base, int row, longint vx, longint vy,
                                       longint vz, bit with_trans);
    longint whole;
    longint frac;
    longint p;
    longint v [3];
    v[0] = vx; v[1] = vy; v[2] = vz;
    whole = 0;
    frac = 0;
    for (int c = 0; c < 3; c++) begin
      p = longint'($signed(coef_mirror[base + row * Cols + c])) * v[c];
      whole += p >>> FracBits;
      frac += p & ((64'sd1 <<< FracBits) - 1);
    end
    if (with_trans) whole += longint'($signed(coef_mirror[base + row * Cols + 3]));
    frac += 64'sd1 <<< (FracBits - 1);
    whole += frac >>> FracBits;
    if (whole > 64'sd2147483647) whole = 64'sd2147483647;
    if (whole < -64'sd2147483648) whole = -64'sd2147483648;
    return whole;
  endfunction

  function automatic result_t transform_vertex(vtx_item_t it);
    result_t r;
    longint  res [3];
    longint  a;
    longint  b;
    longint  wt;
    wt = (it.w > WeightOne) ? WeightOne : it.w;
    for (int row = 0; row < Rows; row++) begin
      if (mode_mirror == ModeRotScale) begin
        res[row] = row_value(0, row, $signed(it.x), $signed(it.y), $signed(it.z), 1'b0);
      end else if (mode_mirror == ModeSkin) begin
        a = row_value(0, row, $signed(it.x), $signed(it.y), $signed(it.z), 1'b1);
        b = row_value(MatSize, row, $signed(it.x), $signed(it.y), $signed(it.z), 1'b1);
        res[row] = (a * wt + b * (WeightOne - wt) + 32768) >>> 16;
      end else begin
        res[row] = row_value(0, row, $signed(it.x), $signed(it.y), $signed(it.z), 1'b1);
      end
    end
    r.x = res[0][31:0];
    r.y = res[1][31:0];
    r.z = res[2][31:0];
    r.last = it.last;
    return r;
  endfunction

  task automatic send_item(vtx_item_t it);
    int gap;
    gap = push_gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= it.cmd;
    matrix_sel_i <= it.sel;
    coef_index_i <= it.idx;
    coef_value_i <= it.coef;
    vert_x_i <= it.x;
    vert_y_i <= it.y;
    vert_z_i <= it.z;
    blend_weight_i <= it.w;
    last_in_i <= it.last;
    do @(posedge clk_i); while (full);
    if (it.cmd == CmdLoad) begin
      if (it.idx < MatSize) coef_mirror[it.sel * MatSize + it.idx] = it.coef;
    end else begin
      expected_q.push_back(transform_vertex(it));
    end
  endtask

  task automatic load_coef(bit sel, int idx, logic [31:0] value);
    vtx_item_t it;
    it = '{cmd: CmdLoad, sel: sel, idx: 4'(idx), coef: value, x: $urandom, y: $urandom,
           z: $urandom, w: 17'($urandom), last: 1'($urandom)};
    send_item(it);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [16:0] w, bit last);
    vtx_item_t it;
    it = '{cmd: CmdVertex, sel: 1'($urandom), idx: 4'($urandom), coef: $urandom,
           x: x, y: y, z: z, w: w, last: last};
    send_item(it);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_mirror = m;
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return 17'($urandom);
      1: return $urandom_range(0, 1) ? 17'd0 : 17'd65536;
      default: return 17'($urandom_range(0, WeightOne));
    endcase
  endfunction

  task automatic test_matrix_load();
    for (int i = 0; i < MatSize; i++) begin
      load_coef(1'b0, i, (i % 5 == 0) ? 32'h0001_0000 : (i % 4 == 3) ? 32'h0003_8000 : '0);
      load_coef(1'b1, i, (i % 5 == 0) ? 32'h0002_0000 : (i % 4 == 3) ? 32'hfffe_0000 : '0);
    end
  endtask

  task automatic test_directed();
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 17'd0, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 17'd65536, 1'b1);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 17'h1ffff, 1'b0);
    send_vertex(32'h0000_8000, 32'hffff_8000, 32'h0000_0001, 17'd32768, 1'b1);
    load_coef(1'b0, 12, 32'hdead_beef);
    load_coef(1'b1, 15, 32'h1234_5678);
    load_coef(1'b0, 0, 32'h7fff_ffff);
    load_coef(1'b1, 5, 32'h8000_0000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 17'd65537, 1'b1);
  endtask

  task automatic test_random(int n_items);
    vtx_item_t it;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        push_gaps_on = $urandom_range(0, 3) != 0;
        pop_stalls_on = $urandom_range(0, 3) != 0;
      end
      it = '{cmd: ($urandom_range(0, 6) != 0) ? CmdVertex : CmdLoad, sel: 1'($urandom),
             idx: ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11)),
             coef: rand_q(), x: rand_q(), y: rand_q(), z: rand_q(), w: rand_weight(),
             last: 1'($urandom)};
      send_item(it);
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat x=%h", out_x_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_x_o !== exp_r.x || out_y_o !== exp_r.y || out_z_o !== exp_r.z ||
            last_out_o !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                     exp_r.x, exp_r.y, exp_r.z, exp_r.last,
                     out_x_o, out_y_o, out_z_o, last_out_o);
        end
      end
      pop_stall = pop_stalls_on ? $urandom_range(0, 12) : 0;
    end
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_matrix_load();
    test_directed();
    set_mode(ModeRotScale);
    test_directed();
    set_mode(ModeSkin);
    test_directed();
    test_random(475);
    set_mode(ModeAffine);
    test_random(475);
    set_mode(ModeSpare);
    test_random(475);
    set_mode(ModeRotScale);
    test_random(475);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/avt_pkg.sv
rtl/avt_front.sv
rtl/avt_back.sv
rtl/avt_resq.sv
rtl/affine_vertex_transform_skin.sv
rtl/avt_checker.sv
tb/sv/tb_affine_vertex_transform_skin.sv
